>>> hw/rtl/sdi_pkg.sv
package sdi_pkg;

  localparam int ModeW     = 3;
  localparam int StepW     = 4;
  localparam int KindW     = 4;
  localparam int ResW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 24;
  localparam int InDataW   = 88;
  localparam int OutDataW  = 72;

  localparam logic [ModeW-1:0] MODE_DETECT   = 3'd0;
  localparam logic [ModeW-1:0] MODE_INIT     = 3'd1;
  localparam logic [ModeW-1:0] MODE_CMD_DONE = 3'd2;
  localparam logic [ModeW-1:0] MODE_READ     = 3'd3;
  localparam logic [ModeW-1:0] MODE_XFER     = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_VOLTAGE_WINDOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_LENGTH   = 2'd2;

  localparam logic [KindW-1:0] RK_NONE   = 4'd0;
  localparam logic [KindW-1:0] RK_R1     = 4'd1;
  localparam logic [KindW-1:0] RK_R1B    = 4'd2;
  localparam logic [KindW-1:0] RK_R2     = 4'd3;
  localparam logic [KindW-1:0] RK_R3     = 4'd4;
  localparam logic [KindW-1:0] RK_R6     = 4'd5;
  localparam logic [KindW-1:0] RK_R7     = 4'd6;
  localparam logic [KindW-1:0] RK_SINGLE = 4'd7;
  localparam logic [KindW-1:0] RK_MULTI  = 4'd8;

  localparam logic [ResW-1:0] RES_PENDING  = 2'd0;
  localparam logic [ResW-1:0] RES_OK       = 2'd1;
  localparam logic [ResW-1:0] RES_FAIL     = 2'd2;
  localparam logic [ResW-1:0] RES_NOTREADY = 2'd3;

  localparam logic [31:0] IF_COND_ECHO  = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_FLAGS  = 32'h5000_0000;
  localparam logic [31:0] BUS4_ARG      = 32'd2;

  localparam logic [15:0] RETRY_LIMIT_RST    = 16'd1000;
  localparam logic [23:0] VOLTAGE_WINDOW_RST = 24'h30_0000;
  localparam logic [11:0] BLOCK_LENGTH_RST   = 12'd512;

  typedef struct packed {
    logic [15:0] retry_limit;
    logic [23:0] voltage_window;
    logic [11:0] block_length;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             card_present;
    logic             cmd_error;
    logic [31:0]      response_word;
    logic [31:0]      read_sector;
    logic [15:0]      read_count;
  } item_t;

  typedef struct packed {
    logic             issue_cmd;
    logic [5:0]       cmd_index;
    logic [31:0]      cmd_argument;
    logic [KindW-1:0] response_kind;
    logic [15:0]      block_count;
    logic             clock_fast;
    logic             bus_wide;
    logic             not_initialized;
    logic             no_disk;
    logic [ResW-1:0]  result_code;
  } result_t;

endpackage

>>> hw/rtl/sdi_cfg.sv
module sdi_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sdi_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sdi_pkg::CfgDataW-1:0]  cfg_data,
  output sdi_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit    <= sdi_pkg::RETRY_LIMIT_RST;
      cfg.voltage_window <= sdi_pkg::VOLTAGE_WINDOW_RST;
      cfg.block_length   <= sdi_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdi_pkg::REG_RETRY_LIMIT:    cfg.retry_limit    <= cfg_data[15:0];
        sdi_pkg::REG_VOLTAGE_WINDOW: cfg.voltage_window <= cfg_data;
        sdi_pkg::REG_BLOCK_LENGTH:   cfg.block_length   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sdi_ctrl.sv
module sdi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  sdi_pkg::item_t    item,
  input  sdi_pkg::cfg_t     cfg,
  output sdi_pkg::result_t  result
);

  localparam logic [sdi_pkg::StepW-1:0] STEP_IDLE   = 4'd0;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD0   = 4'd1;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD8   = 4'd2;
  localparam logic [sdi_pkg::StepW-1:0] STEP_APP1   = 4'd3;
  localparam logic [sdi_pkg::StepW-1:0] STEP_ACMD41 = 4'd4;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD2   = 4'd5;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD3   = 4'd6;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD9   = 4'd7;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD7   = 4'd8;
  localparam logic [sdi_pkg::StepW-1:0] STEP_APP2   = 4'd9;
  localparam logic [sdi_pkg::StepW-1:0] STEP_ACMD6  = 4'd10;
  localparam logic [sdi_pkg::StepW-1:0] STEP_CMD16  = 4'd11;

  logic [sdi_pkg::StepW-1:0] step, step_next;
  logic [15:0]               card_address, card_address_next;
  logic [15:0]               retries_left, retries_left_next;
  logic                      uninit, uninit_next;
  logic                      absent, absent_next;
  logic                      fast_clk, fast_clk_next;
  logic                      wide_bus, wide_bus_next;
  logic                      read_busy, read_busy_next;
  logic [31:0]               addr_arg;
  sdi_pkg::result_t          res;

  assign addr_arg = {card_address_next, 16'h0000};

  always_comb begin
    step_next         = step;
    card_address_next = card_address;
    retries_left_next = retries_left;
    uninit_next       = uninit;
    absent_next       = absent;
    fast_clk_next     = fast_clk;
    wide_bus_next     = wide_bus;
    read_busy_next    = read_busy;
    res               = '0;

    unique case (item.mode)
      sdi_pkg::MODE_DETECT: begin
        absent_next    = ~item.card_present;
        uninit_next    = 1'b1;
        step_next      = STEP_IDLE;
        read_busy_next = 1'b0;
      end
      sdi_pkg::MODE_INIT: begin
        uninit_next    = 1'b1;
        fast_clk_next  = 1'b0;
        wide_bus_next  = 1'b0;
        read_busy_next = 1'b0;
        if (absent) begin
          step_next       = STEP_IDLE;
          res.result_code = sdi_pkg::RES_NOTREADY;
        end else begin
          step_next     = STEP_CMD0;
          res.issue_cmd = 1'b1;
        end
      end
      sdi_pkg::MODE_CMD_DONE: begin
        if (step != STEP_IDLE) begin
          if (item.cmd_error) begin
            step_next       = STEP_IDLE;
            res.result_code = sdi_pkg::RES_FAIL;
          end else begin
            unique case (step)
              STEP_CMD0: begin
                step_next          = STEP_CMD8;
                res.issue_cmd      = 1'b1;
                res.cmd_index      = 6'd8;
                res.cmd_argument   = sdi_pkg::IF_COND_ECHO;
                res.response_kind  = sdi_pkg::RK_R7;
              end
              STEP_CMD8: begin
                if (item.response_word != sdi_pkg::IF_COND_ECHO) begin
                  step_next       = STEP_IDLE;
                  res.result_code = sdi_pkg::RES_FAIL;
                end else begin
                  card_address_next = '0;
                  retries_left_next = cfg.retry_limit;
                  step_next         = STEP_APP1;
                  res.issue_cmd     = 1'b1;
                  res.cmd_index     = 6'd55;
                  res.cmd_argument  = addr_arg;
                  res.response_kind = sdi_pkg::RK_R1;
                end
              end
              STEP_APP1: begin
                step_next         = STEP_ACMD41;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd41;
                res.cmd_argument  = sdi_pkg::ACMD41_FLAGS | {8'h00, cfg.voltage_window};
                res.response_kind = sdi_pkg::RK_R3;
              end
              STEP_ACMD41: begin
                if ((item.response_word[23:0] & cfg.voltage_window) == '0) begin
                  step_next       = STEP_IDLE;
                  res.result_code = sdi_pkg::RES_FAIL;
                end else if (item.response_word[31] || retries_left <= 16'd1) begin
                  retries_left_next = '0;
                  step_next         = STEP_CMD2;
                  res.issue_cmd     = 1'b1;
                  res.cmd_index     = 6'd2;
                  res.response_kind = sdi_pkg::RK_R2;
                end else begin
                  retries_left_next = retries_left - 16'd1;
                  step_next         = STEP_APP1;
                  res.issue_cmd     = 1'b1;
                  res.cmd_index     = 6'd55;
                  res.cmd_argument  = addr_arg;
                  res.response_kind = sdi_pkg::RK_R1;
                end
              end
              STEP_CMD2: begin
                step_next         = STEP_CMD3;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd3;
                res.response_kind = sdi_pkg::RK_R6;
              end
              STEP_CMD3: begin
                card_address_next = item.response_word[31:16];
                step_next         = STEP_CMD9;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd9;
                res.cmd_argument  = addr_arg;
                res.response_kind = sdi_pkg::RK_R2;
              end
              STEP_CMD9: begin
                fast_clk_next     = 1'b1;
                step_next         = STEP_CMD7;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd7;
                res.cmd_argument  = addr_arg;
                res.response_kind = sdi_pkg::RK_R1B;
              end
              STEP_CMD7: begin
                step_next         = STEP_APP2;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd55;
                res.cmd_argument  = addr_arg;
                res.response_kind = sdi_pkg::RK_R1;
              end
              STEP_APP2: begin
                step_next         = STEP_ACMD6;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd6;
                res.cmd_argument  = sdi_pkg::BUS4_ARG;
                res.response_kind = sdi_pkg::RK_R1;
              end
              STEP_ACMD6: begin
                wide_bus_next     = 1'b1;
                step_next         = STEP_CMD16;
                res.issue_cmd     = 1'b1;
                res.cmd_index     = 6'd16;
                res.cmd_argument  = {20'h00000, cfg.block_length};
                res.response_kind = sdi_pkg::RK_R1;
              end
              STEP_CMD16: begin
                uninit_next     = 1'b0;
                step_next       = STEP_IDLE;
                res.result_code = sdi_pkg::RES_OK;
              end
              default: step_next = STEP_IDLE;
            endcase
          end
        end else if (read_busy && item.cmd_error) begin
          read_busy_next  = 1'b0;
          res.result_code = sdi_pkg::RES_FAIL;
        end
      end
      sdi_pkg::MODE_READ: begin
        if (uninit) begin
          res.result_code = sdi_pkg::RES_NOTREADY;
        end else begin
          read_busy_next   = 1'b1;
          res.issue_cmd    = 1'b1;
          res.cmd_argument = item.read_sector;
          if (item.read_count == 16'd1) begin
            res.cmd_index     = 6'd17;
            res.response_kind = sdi_pkg::RK_SINGLE;
          end else begin
            res.cmd_index     = 6'd18;
            res.response_kind = sdi_pkg::RK_MULTI;
            res.block_count   = item.read_count;
          end
        end
      end
      sdi_pkg::MODE_XFER: begin
        if (read_busy) begin
          read_busy_next  = 1'b0;
          res.result_code = item.cmd_error ? sdi_pkg::RES_FAIL : sdi_pkg::RES_OK;
        end
      end
      default: ;
    endcase

    res.clock_fast      = fast_clk_next;
    res.bus_wide        = wide_bus_next;
    res.not_initialized = uninit_next;
    res.no_disk         = absent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_IDLE;
      card_address <= '0;
      retries_left <= '0;
      uninit       <= 1'b1;
      absent       <= 1'b1;
      fast_clk     <= 1'b0;
      wide_bus     <= 1'b0;
      read_busy    <= 1'b0;
    end else if (step_en) begin
      step         <= step_next;
      card_address <= card_address_next;
      retries_left <= retries_left_next;
      uninit       <= uninit_next;
      absent       <= absent_next;
      fast_clk     <= fast_clk_next;
      wide_bus     <= wide_bus_next;
      read_busy    <= read_busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= res;
    end
  end

endmodule

>>> hw/rtl/sd_card_init_sequencer.sv
// SD card bring-up and read command sequencer. Each input item (an event
// selected by s_tuser: card detect, start init, command done, start read,
// transfer done) yields exactly one result item that may carry one SD
// command to send plus the current clock, bus and card flags and a result
// code. An item is registered on entry and its result is then registered in
// the output register; a new item is taken every cycle while the output side
// keeps up. The event handler is a one-step state update, so the dependence
// of each event on the previous one closes in that single update. The user
// must write configuration (retry limit, OCR voltage window, block length) via
// cfg_we/cfg_index/cfg_data only while no item is in flight; not enforced here.
module sd_card_init_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] card_present, [1] cmd_error, [33:2] response_word,
  // [65:34] read_sector, [81:66] read_count, rest zero
  input  logic [sdi_pkg::InDataW-1:0]   s_tdata,
  // [2:0] mode
  input  logic [sdi_pkg::ModeW-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] issue_cmd, [6:1] cmd_index, [38:7] cmd_argument,
  // [42:39] response_kind, [58:43] block_count, [59] clock_fast,
  // [60] bus_wide, [61] not_initialized, [62] no_disk,
  // [64:63] result_code, rest zero
  output logic [sdi_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_we,
  input  logic [sdi_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sdi_pkg::CfgDataW-1:0]  cfg_data
);

  sdi_pkg::cfg_t    cfg;
  sdi_pkg::item_t   item;
  sdi_pkg::result_t result;
  logic             in_valid;
  logic             adv;

  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = ~in_valid | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.mode          <= s_tuser;
      item.card_present  <= s_tdata[0];
      item.cmd_error     <= s_tdata[1];
      item.response_word <= s_tdata[33:2];
      item.read_sector   <= s_tdata[65:34];
      item.read_count    <= s_tdata[81:66];
    end
  end

  sdi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .step_en (in_valid & adv),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  assign m_tdata = {7'b0,
                    result.result_code,
                    result.no_disk,
                    result.not_initialized,
                    result.bus_wide,
                    result.clock_fast,
                    result.block_count,
                    result.response_kind,
                    result.cmd_argument,
                    result.cmd_index,
                    result.issue_cmd};

endmodule

>>> hw/rtl/sdi_checker.sv
module sdi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sdi_pkg::OutDataW-1:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0 && m_tdata[38:7] == 32'd0
      && m_tdata[42:39] == sdi_pkg::RK_NONE)
    else $error("command fields set without a command");

  a_notready_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64:63] == sdi_pkg::RES_NOTREADY |-> !m_tdata[0])
    else $error("command issued with not-ready result");

  a_nodisk_uninit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[62] |-> m_tdata[61])
    else $error("initialized with no card");

  a_wide_fast: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[60] |-> m_tdata[59])
    else $error("wide bus without fast clock");

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdi_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 195;

  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
  localparam logic [5:0] CMD_BUS_WIDTH  = 6'd6;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
  localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
  localparam logic [5:0] CMD_READ_ONE   = 6'd17;
  localparam logic [5:0] CMD_READ_MANY  = 6'd18;
  localparam logic [5:0] CMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;

  typedef enum logic [StepW-1:0] {
    ST_IDLE, ST_CMD0, ST_CMD8, ST_APP1, ST_ACMD41, ST_CMD2, ST_CMD3,
    ST_CMD9, ST_CMD7, ST_APP2, ST_ACMD6, ST_CMD16
  } seq_step_t;

  // tracks card bring-up state and holds the result items still owed
  class sd_cmd_book;
    logic [15:0] retry_limit;
    logic [23:0] vwin;
    logic [11:0] blen;
    seq_step_t   step;
    logic [15:0] rca;
    logic [15:0] retries;
    logic        uninit, absent, fast, wide, busy;
    result_t     owed_q[$];
    result_t     nxt;
    int          fails;

    function new();
      retry_limit = RETRY_LIMIT_RST;
      vwin        = VOLTAGE_WINDOW_RST;
      blen        = BLOCK_LENGTH_RST;
      step        = ST_IDLE;
      rca         = '0;
      retries     = '0;
      uninit      = 1'b1;
      absent      = 1'b1;
      fast        = 1'b0;
      wide        = 1'b0;
      busy        = 1'b0;
      fails       = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_RETRY_LIMIT:    retry_limit = val[15:0];
        REG_VOLTAGE_WINDOW: vwin = val;
        REG_BLOCK_LENGTH:   blen = val[11:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void launch(seq_step_t s, logic [5:0] idx, logic [31:0] arg,
                         logic [KindW-1:0] kind);
      step = s;
      nxt.issue_cmd     = 1'b1;
      nxt.cmd_index     = idx;
      nxt.cmd_argument  = arg;
      nxt.response_kind = kind;
    endfunction

    function void stop_chain();
      step = ST_IDLE;
      nxt.result_code = RES_FAIL;
    endfunction

    function void command_done(logic err, logic [31:0] resp);
      if (err) begin
        stop_chain();
        return;
      end
      case (step)
        ST_CMD0: launch(ST_CMD8, CMD_IF_COND, IF_COND_ECHO, RK_R7);
        ST_CMD8: begin
          if (resp != IF_COND_ECHO) begin
            stop_chain();
          end else begin
            rca = '0;
            retries = retry_limit;
            launch(ST_APP1, CMD_APP, {rca, 16'd0}, RK_R1);
          end
        end
        ST_APP1: launch(ST_ACMD41, CMD_OP_COND, ACMD41_FLAGS | {8'd0, vwin}, RK_R3);
        ST_ACMD41: begin
          if ((resp & {8'd0, vwin}) == '0) begin
            stop_chain();
          end else if (resp[31] || retries <= 16'd1) begin
            retries = '0;
            launch(ST_CMD2, CMD_ALL_CID, '0, RK_R2);
          end else begin
            retries = retries - 16'd1;
            launch(ST_APP1, CMD_APP, {rca, 16'd0}, RK_R1);
          end
        end
        ST_CMD2: launch(ST_CMD3, CMD_SEND_RCA, '0, RK_R6);
        ST_CMD3: begin
          rca = resp[31:16];
          launch(ST_CMD9, CMD_SEND_CSD, {rca, 16'd0}, RK_R2);
        end
        ST_CMD9: begin
          fast = 1'b1;
          launch(ST_CMD7, CMD_SELECT, {rca, 16'd0}, RK_R1B);
        end
        ST_CMD7: launch(ST_APP2, CMD_APP, {rca, 16'd0}, RK_R1);
        ST_APP2: launch(ST_ACMD6, CMD_BUS_WIDTH, BUS4_ARG, RK_R1);
        ST_ACMD6: begin
          wide = 1'b1;
          launch(ST_CMD16, CMD_BLOCKLEN, {20'd0, blen}, RK_R1);
        end
        ST_CMD16: begin
          uninit = 1'b0;
          step = ST_IDLE;
          nxt.result_code = RES_OK;
        end
        default: step = ST_IDLE;
      endcase
    endfunction

    function void note_event(item_t ev);
      nxt = '0;
      case (ev.mode)
        MODE_DETECT: begin
          absent = !ev.card_present;
          uninit = 1'b1;
          step   = ST_IDLE;
          busy   = 1'b0;
        end
        MODE_INIT: begin
          uninit = 1'b1;
          fast   = 1'b0;
          wide   = 1'b0;
          busy   = 1'b0;
          step   = ST_IDLE;
          if (absent) nxt.result_code = RES_NOTREADY;
          else launch(ST_CMD0, CMD_GO_IDLE, '0, RK_NONE);
        end
        MODE_CMD_DONE: begin
          if (step != ST_IDLE) begin
            command_done(ev.cmd_error, ev.response_word);
          end else if (busy && ev.cmd_error) begin
            busy = 1'b0;
            nxt.result_code = RES_FAIL;
          end
        end
        MODE_READ: begin
          if (uninit) begin
            nxt.result_code = RES_NOTREADY;
          end else begin
            busy = 1'b1;
            nxt.issue_cmd    = 1'b1;
            nxt.cmd_argument = ev.read_sector;
            if (ev.read_count == 16'd1) begin
              nxt.cmd_index     = CMD_READ_ONE;
              nxt.response_kind = RK_SINGLE;
            end else begin
              nxt.cmd_index     = CMD_READ_MANY;
              nxt.response_kind = RK_MULTI;
              nxt.block_count   = ev.read_count;
            end
          end
        end
        MODE_XFER: begin
          if (busy) begin
            busy = 1'b0;
            nxt.result_code = ev.cmd_error ? RES_FAIL : RES_OK;
          end
        end
        default: ;
      endcase
      nxt.clock_fast      = fast;
      nxt.bus_wide        = wide;
      nxt.not_initialized = uninit;
      nxt.no_disk         = absent;
      owed_q.push_back(nxt);
    endfunction

    function string show(result_t r);
      return $sformatf({"issue=%0d idx=%0d arg=%h kind=%0d cnt=%h ",
                        "fast=%0d wide=%0d uninit=%0d nodisk=%0d res=%0d"},
                       r.issue_cmd, r.cmd_index, r.cmd_argument, r.response_kind,
                       r.block_count, r.clock_fast, r.bus_wide, r.not_initialized,
                       r.no_disk, r.result_code);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%0t unexpected item: %s", $realtime, show(got));
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t mismatch", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [ModeW-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  sd_cmd_book book = new();
  logic       calm = 1'b0;
  int         events_to_go = 0;
  int         stall_cycles = 0;

  logic [15:0] retry_plan  [PHASES] = '{16'd1, 16'd3, 16'd0, 16'd65535,
                                        16'd2, 16'd5, 16'd1000, 16'd7};
  logic [23:0] window_plan [PHASES] = '{24'hFF_FFFF, 24'h30_0000, 24'h00_0001, 24'h80_0000,
                                        24'h00_0000, 24'h0F_00F0, 24'hFF_8000, 24'h30_0000};
  logic [11:0] length_plan [PHASES] = '{12'd1, 12'hFFF, 12'd2048, 12'd512,
                                        12'd0, 12'd1000, 12'd1, 12'd2048};

  sd_card_init_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.issue_cmd       = m_tdata[0];
      got.cmd_index       = m_tdata[6:1];
      got.cmd_argument    = m_tdata[38:7];
      got.response_kind   = m_tdata[42:39];
      got.block_count     = m_tdata[58:43];
      got.clock_fast      = m_tdata[59];
      got.bus_wide        = m_tdata[60];
      got.not_initialized = m_tdata[61];
      got.no_disk         = m_tdata[62];
      got.result_code     = m_tdata[64:63];
      book.check_reply(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sd_card_init_sequencer test failed");
        $finish;
      end
    end
  end

  function automatic item_t mk(logic [ModeW-1:0] mode, logic present, logic err,
                               logic [31:0] resp, logic [31:0] sector, logic [15:0] count);
    item_t ev;
    ev.mode          = mode;
    ev.card_present  = present;
    ev.cmd_error     = err;
    ev.response_word = resp;
    ev.read_sector   = sector;
    ev.read_count    = count;
    return ev;
  endfunction

  // response the card would plausibly give for the command now in flight
  function automatic logic [31:0] reply_for(seq_step_t st);
    logic [31:0] w;
    int          b;
    w = $urandom();
    case (st)
      ST_CMD8: if ($urandom_range(0, 99) < 92) w = IF_COND_ECHO;
      ST_ACMD41: begin
        if (book.vwin != '0 && $urandom_range(0, 99) < 92) begin
          b = $urandom_range(0, 23);
          while (!book.vwin[b]) b = $urandom_range(0, 23);
          w[b] = 1'b1;
        end
        w[31] = ($urandom_range(0, 99) < 30);
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_event(input item_t ev);
    while (!calm && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev.mode;
    s_tdata  <= {6'd0, ev.read_count, ev.read_sector, ev.response_word,
                 ev.cmd_error, ev.card_present};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_event(ev);
    if (ev.mode <= MODE_XFER) events_to_go--;
  endtask

  task automatic program_regs(input logic [15:0] retry, input logic [23:0] vw,
                              input logic [11:0] blen);
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RETRY_LIMIT;
    cfg_data  <= {8'd0, retry};
    @(posedge clk);
    book.set_reg(REG_RETRY_LIMIT, {8'd0, retry});
    cfg_index <= REG_VOLTAGE_WINDOW;
    cfg_data  <= vw;
    @(posedge clk);
    book.set_reg(REG_VOLTAGE_WINDOW, vw);
    cfg_index <= REG_BLOCK_LENGTH;
    cfg_data  <= {12'd0, blen};
    @(posedge clk);
    book.set_reg(REG_BLOCK_LENGTH, {12'd0, blen});
    cfg_we <= 1'b0;
  endtask

  task automatic read_once();
    logic [15:0] n;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) n = 16'd1;
    else if (pick < 40) n = 16'd0;
    else if (pick < 45) n = 16'hFFFF;
    else n = 16'($urandom());
    send_event(mk(MODE_READ, 1'($urandom()), 1'($urandom()), $urandom(), $urandom(), n));
    pick = $urandom_range(0, 99);
    if (pick < 85)
      send_event(mk(MODE_CMD_DONE, 1'($urandom()), $urandom_range(0, 99) < 8,
                    $urandom(), $urandom(), 16'($urandom())));
    if (pick < 93 && book.busy)
      send_event(mk(MODE_XFER, 1'($urandom()), $urandom_range(0, 99) < 20,
                    $urandom(), $urandom(), 16'($urandom())));
    if ($urandom_range(0, 99) < 5)
      send_event(mk($urandom_range(0, 1) ? MODE_XFER : MODE_CMD_DONE, 1'($urandom()),
                    1'($urandom()), $urandom(), $urandom(), 16'($urandom())));
  endtask

  task automatic bring_up_and_read();
    if ($urandom_range(0, 99) < 8)
      send_event(mk(MODE_DETECT, $urandom_range(0, 99) < 85, 1'($urandom()),
                    $urandom(), $urandom(), 16'($urandom())));
    send_event(mk(MODE_INIT, 1'($urandom()), 1'($urandom()), $urandom(), $urandom(),
                  16'($urandom())));
    while (book.step != ST_IDLE && events_to_go > 0) begin
      if ($urandom_range(0, 99) < 3)
        send_event(mk(3'($urandom_range(0, 7)), 1'($urandom()), 1'($urandom()),
                      $urandom(), $urandom(), 16'($urandom())));
      else
        send_event(mk(MODE_CMD_DONE, 1'($urandom()), $urandom_range(0, 99) < 3,
                      reply_for(book.step), $urandom(), 16'($urandom())));
    end
    if (!book.uninit) begin
      repeat ($urandom_range(1, 12)) begin
        if (events_to_go > 0 && !book.uninit) read_once();
      end
    end
  endtask

  initial begin
    logic [15:0] r;
    logic [23:0] v;
    logic [11:0] l;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // no card yet: stray events and requests
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_READ, 1'b0, 1'b0, '0, '0, 16'd1));
    send_event(mk(MODE_INIT, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_XFER, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_DETECT, 1'b1, 1'b0, '0, '0, '0));
    // full bring-up with one busy ACMD41 round
    send_event(mk(MODE_INIT, 1'b1, 1'b0, '0, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, IF_COND_ECHO, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, 32'h0010_0000, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, 32'hFFFF_FFFF, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, 32'hFFFF_0000, '0, '0));
    repeat (5) send_event(mk(MODE_CMD_DONE, 1'b0, 1'b0, '0, '0, '0));
    // reads: zero count, restart, command error, single block, transfer error
    send_event(mk(MODE_READ, 1'b0, 1'b0, '0, 32'hFFFF_FFFF, 16'd0));
    send_event(mk(MODE_READ, 1'b0, 1'b0, '0, '0, 16'hFFFF));
    send_event(mk(MODE_CMD_DONE, 1'b0, 1'b1, '0, '0, '0));
    send_event(mk(MODE_READ, 1'b0, 1'b0, '0, 32'h1234_5678, 16'd1));
    send_event(mk(MODE_XFER, 1'b0, 1'b1, '0, '0, '0));
    send_event(mk(3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_event(mk(MODE_DETECT, 1'b0, 1'b0, '0, '0, '0));

    for (int ph = 0; ph < PHASES; ph++) begin
      r = retry_plan[ph];
      v = window_plan[ph];
      l = length_plan[ph];
      if (ph == PHASES - 1) begin
        r = 16'($urandom_range(1, 40));
        v = 24'($urandom());
        l = 12'($urandom_range(1, 2048));
      end
      calm = (ph == 3);
      program_regs(r, v, l);
      events_to_go = PHASE_ITEMS;
      while (events_to_go > 0) bring_up_and_read();
    end
    calm = 1'b0;

    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.fails == 0 && book.pending() == 0) begin
      $display("sd_card_init_sequencer test passed");
    end else begin
      $display("sd_card_init_sequencer test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sdi_pkg.sv
hw/rtl/sdi_cfg.sv
hw/rtl/sdi_ctrl.sv
hw/rtl/sd_card_init_sequencer.sv
hw/rtl/sdi_checker.sv
sim/testbench.sv
